>>> sv/dfps_pkg.sv
// types, constants and arithmetic helpers for the double to float pair split
package dfps_pkg;

  localparam logic [63:0] DblQuietBit  = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DblDefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [31:0] FltInf       = 32'h7F80_0000;
  localparam logic [31:0] FltQuietBit  = 32'h0040_0000;
  localparam int          Latency      = 15;

  // unrounded result: value = mant * 2^(sc - 1075)
  typedef struct packed {
    logic               sign;
    logic               spec;
    logic [63:0]        spec_bits;
    logic signed [12:0] sc;
    logic [85:0]        mant;
  } unr_t;

  // normalised result: mant msb at bit 85, ex is the biased exponent
  typedef struct packed {
    logic               sign;
    logic               spec;
    logic [63:0]        spec_bits;
    logic signed [12:0] ex;
    logic [85:0]        mant;
  } nrm_t;

  function automatic logic [6:0] lzc86(input logic [85:0] v);
    logic [6:0] n;
    n = 7'd86;
    for (int i = 0; i < 86; i++) begin
      if (v[i]) n = 7'(85 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] n;
    n = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) n = 5'(22 - i);
    end
    return n;
  endfunction

  // a * (2^29 + 1): a shifted add, exact before rounding
  function automatic unr_t fp_mul_split(input logic [63:0] a);
    logic        is_nan, is_inf;
    logic [10:0] ea;
    logic [52:0] m;
    logic [82:0] p;
    unr_t        r;
    is_nan = (&a[62:52]) & (|a[51:0]);
    is_inf = (&a[62:52]) & ~(|a[51:0]);
    ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    m = {|a[62:52], a[51:0]};
    p = ({30'b0, m} << 29) + {30'b0, m};
    r.sign = a[63];
    r.spec = is_nan | is_inf;
    r.spec_bits = is_nan ? (a | DblQuietBit) : a;
    r.sc = $signed({2'b00, ea});
    r.mant = {3'b000, p};
    return r;
  endfunction

  // x - y with guard, round and sticky bits
  function automatic unr_t fp_sub(input logic [63:0] x, input logic [63:0] y);
    logic        xs, ys, bs, ss;
    logic        xnan, ynan, xinf, yinf;
    logic [10:0] xe, ye, eb, es, d;
    logic [52:0] xm, ym, mb, ms;
    logic [5:0]  dc;
    logic [111:0] al;
    logic [55:0] sm;
    logic [56:0] sum;
    unr_t        r;
    xs = x[63];
    ys = ~y[63];
    xnan = (&x[62:52]) & (|x[51:0]);
    ynan = (&y[62:52]) & (|y[51:0]);
    xinf = (&x[62:52]) & ~(|x[51:0]);
    yinf = (&y[62:52]) & ~(|y[51:0]);
    xe = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    ye = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
    xm = {|x[62:52], x[51:0]};
    ym = {|y[62:52], y[51:0]};
    if ({xe, xm} >= {ye, ym}) begin
      eb = xe; mb = xm; bs = xs; es = ye; ms = ym; ss = ys;
    end else begin
      eb = ye; mb = ym; bs = ys; es = xe; ms = xm; ss = xs;
    end
    d = eb - es;
    dc = (d > 11'd56) ? 6'd57 : d[5:0];
    al = {ms, 3'b000, 56'b0} >> dc;
    sm = {al[111:57], al[56] | (|al[55:0])};
    if (bs == ss) sum = {1'b0, mb, 3'b000} + {1'b0, sm};
    else          sum = {1'b0, mb, 3'b000} - {1'b0, sm};
    r.mant = {29'b0, sum};
    r.sc = $signed({2'b00, eb}) - 13'sd3;
    r.sign = (sum == 57'd0) ? (xs & ys) : bs;
    r.spec = 1'b0;
    r.spec_bits = '0;
    if (xnan) begin
      r.spec = 1'b1; r.spec_bits = x | DblQuietBit;
    end else if (ynan) begin
      r.spec = 1'b1; r.spec_bits = y | DblQuietBit;
    end else if (xinf && yinf) begin
      r.spec = 1'b1; r.spec_bits = (xs == ys) ? x : DblDefaultNan;
    end else if (xinf) begin
      r.spec = 1'b1; r.spec_bits = x;
    end else if (yinf) begin
      r.spec = 1'b1; r.spec_bits = {ys, y[62:0]};
    end
    return r;
  endfunction

  function automatic nrm_t fp_norm(input unr_t u);
    logic [6:0] lz;
    nrm_t       n;
    lz = lzc86(u.mant);
    n.sign = u.sign;
    n.spec = u.spec;
    n.spec_bits = u.spec_bits;
    n.ex = u.sc - $signed({6'b0, lz}) + 13'sd33;
    n.mant = u.mant << lz;
    return n;
  endfunction

  function automatic logic [63:0] fp_round(input nrm_t n);
    logic [6:0]   sh;
    logic [141:0] w;
    logic [52:0]  sig;
    logic         g, st, inc;
    logic [53:0]  r;
    logic signed [12:0] ef;
    logic [63:0]  res;
    sh = (n.ex < 13'sd1) ? 7'(13'sd1 - n.ex) : 7'd0;
    if (sh > 7'd60) sh = 7'd60;
    w = {n.mant, 56'b0} >> sh;
    sig = w[141:89];
    g = w[88];
    st = |w[87:0];
    inc = g & (st | sig[0]);
    r = {1'b0, sig} + {53'b0, inc};
    if (n.ex < 13'sd1) begin
      res = {n.sign, 10'b0, r[52], r[51:0]};
    end else begin
      ef = r[53] ? n.ex + 13'sd1 : n.ex;
      if (ef >= 13'sd2047) res = {n.sign, 11'h7FF, 52'b0};
      else res = {n.sign, ef[10:0], r[53] ? 52'b0 : r[51:0]};
    end
    if (n.mant == 86'd0) res = {n.sign, 63'b0};
    if (n.spec) res = n.spec_bits;
    return res;
  endfunction

  function automatic logic [31:0] narrow(input logic [63:0] d);
    logic        s;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic signed [12:0] fe;
    logic [24:0] r;
    logic        inc;
    logic [6:0]  sh;
    logic [106:0] w;
    logic [31:0] res;
    s = d[63];
    e = d[62:52];
    m = d[51:0];
    sig = {1'b1, m};
    fe = $signed({2'b00, e}) - 13'sd896;
    if (fe >= 13'sd1) begin
      inc = sig[28] & ((|sig[27:0]) | sig[29]);
      r = {1'b0, sig[52:29]} + {24'b0, inc};
      if (r[24]) fe = fe + 13'sd1;
      if (fe >= 13'sd255) res = {s, FltInf[30:0]};
      else res = {s, fe[7:0], r[24] ? 23'b0 : r[22:0]};
    end else begin
      sh = (fe < -13'sd30) ? 7'd60 : 7'(13'sd30 - fe);
      if (sh > 7'd54) begin
        res = {s, 31'b0};
      end else begin
        w = {sig, 54'b0} >> sh;
        inc = w[53] & ((|w[52:0]) | w[54]);
        r = w[78:54] + {24'b0, inc};
        res = {s, 6'b0, r};
      end
    end
    if (e == 11'd0) res = {s, 31'b0};
    if (e == 11'h7FF) begin
      res = (m == 52'd0) ? {s, FltInf[30:0]} : ({s, FltInf[30:0]} | FltQuietBit | {9'b0, m[51:29]});
    end
    return res;
  endfunction

  // exact float to double widening
  function automatic logic [63:0] widen(input logic [31:0] f);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m, mn;
    logic [4:0]  lz;
    logic [63:0] res;
    s = f[31];
    e = f[30:23];
    m = f[22:0];
    lz = lzc23(m);
    mn = m << (lz + 5'd1);
    if (e == 8'hFF) res = {s, 11'h7FF, m, 29'b0};
    else if (e == 8'd0) begin
      if (m == 23'd0) res = {s, 63'b0};
      else res = {s, 11'(11'd896 - {6'b0, lz}), mn, 29'b0};
    end else res = {s, 11'({3'b0, e} + 11'd896), m, 29'b0};
    return res;
  endfunction

endpackage

>>> sv/double_to_float_pair_split.sv
// double to float pair split: veltkamp split of a binary64 into two binary32 parts
// channels: one input beat carries value_bits_i (a binary64 pattern) under
// valid_i / stall_o; one output beat carries high_part_bits_o and
// low_part_bits_o under valid_o / stall_i. a beat moves on a rising edge
// where valid is high and stall is low.
// every input beat gives exactly one output beat, in order.
// throughput is one beat per cycle unless the receiver stalls a held
// result. the pipeline has 15 register stages: three per double
// operation (align and add, normalise, round) for the splitter product and
// the three subtractions, plus narrowing and widening stages.
// when the receiver stalls with a result waiting, the whole pipeline
// holds and stall_o rises in the same cycle; bubbles still move while the
// last stage is empty.
// reset clears all valid bits; data registers are not reset.
module double_to_float_pair_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] value_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] high_part_bits_o,
  output logic [31:0] low_part_bits_o
);

  localparam int N = dfps_pkg::Latency;

  logic [N-1:0] vld_q;
  logic         en;

  logic [63:0] a1_q, a2_q, a3_q, a4_q, a5_q, a6_q, a7_q, a8_q, a9_q, a10_q, a11_q;
  logic [63:0] t3_q, t4_q, t5_q, t6_q, u6_q, h9_q, hw11_q, l14_q;
  logic [31:0] hi10_q, hi11_q, hi12_q, hi13_q, hi14_q, hi15_q, lo15_q;
  dfps_pkg::unr_t t_u_q, u_u_q, h_u_q, l_u_q;
  dfps_pkg::nrm_t t_n_q, u_n_q, h_n_q, l_n_q;

  dfps_pkg::unr_t t_u_d, u_u_d, h_u_d, l_u_d;
  dfps_pkg::nrm_t t_n_d, u_n_d, h_n_d, l_n_d;
  logic [63:0] t3_d, u6_d, h9_d, hw11_d, l14_d;
  logic [31:0] hi10_d, lo15_d;

  // a held result blocks every stage behind it
  assign en = ~(vld_q[N-1] & stall_i);
  assign stall_o = ~en;

  always_comb begin
    t_u_d  = dfps_pkg::fp_mul_split(value_bits_i);
    t_n_d  = dfps_pkg::fp_norm(t_u_q);
    t3_d   = dfps_pkg::fp_round(t_n_q);
    u_u_d  = dfps_pkg::fp_sub(t3_q, a3_q);
    u_n_d  = dfps_pkg::fp_norm(u_u_q);
    u6_d   = dfps_pkg::fp_round(u_n_q);
    h_u_d  = dfps_pkg::fp_sub(t6_q, u6_q);
    h_n_d  = dfps_pkg::fp_norm(h_u_q);
    h9_d   = dfps_pkg::fp_round(h_n_q);
    hi10_d = dfps_pkg::narrow(h9_q);
    hw11_d = dfps_pkg::widen(hi10_q);
    l_u_d  = dfps_pkg::fp_sub(a11_q, hw11_q);
    l_n_d  = dfps_pkg::fp_norm(l_u_q);
    l14_d  = dfps_pkg::fp_round(l_n_q);
    lo15_d = dfps_pkg::narrow(l14_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= value_bits_i;  t_u_q <= t_u_d;
      a2_q <= a1_q;          t_n_q <= t_n_d;
      a3_q <= a2_q;          t3_q <= t3_d;
      a4_q <= a3_q;          t4_q <= t3_q;   u_u_q <= u_u_d;
      a5_q <= a4_q;          t5_q <= t4_q;   u_n_q <= u_n_d;
      a6_q <= a5_q;          t6_q <= t5_q;   u6_q <= u6_d;
      a7_q <= a6_q;          h_u_q <= h_u_d;
      a8_q <= a7_q;          h_n_q <= h_n_d;
      a9_q <= a8_q;          h9_q <= h9_d;
      a10_q <= a9_q;         hi10_q <= hi10_d;
      a11_q <= a10_q;        hi11_q <= hi10_q; hw11_q <= hw11_d;
      hi12_q <= hi11_q;      l_u_q <= l_u_d;
      hi13_q <= hi12_q;      l_n_q <= l_n_d;
      hi14_q <= hi13_q;      l14_q <= l14_d;
      hi15_q <= hi14_q;      lo15_q <= lo15_d;
    end
  end

  assign valid_o          = vld_q[N-1];
  assign high_part_bits_o = hi15_q;
  assign low_part_bits_o  = lo15_q;

endmodule

>>> sv/dfps_checker.sv
// port checker for the double to float pair split, bound to the top level
module dfps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] high_part_bits_o,
  input logic [31:0] low_part_bits_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(high_part_bits_o) && $stable(low_part_bits_o))
    else $error("output payload changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a held result");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while the receiver takes beats");

endmodule

bind double_to_float_pair_split dfps_checker u_dfps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .stall_o          (stall_o),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .high_part_bits_o (high_part_bits_o),
  .low_part_bits_o  (low_part_bits_o)
);

>>> bench/double_to_float_pair_split_test.sv
// testbench for the double to float pair split: predicted hi/lo parts checked beat by beat
`timescale 1ns / 100ps

module double_to_float_pair_split_test;

  localparam real SplitFactor = 536870913.0;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [63:0] value_bits_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] high_part_bits_o;
  logic [31:0] low_part_bits_o;

  logic [63:0] pending_parts[$];
  int          mismatches = 0;
  int          burst_left;
  int          stall_mode;

  double_to_float_pair_split dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .value_bits_i     (value_bits_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .high_part_bits_o (high_part_bits_o),
    .low_part_bits_o  (low_part_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // binary64 to binary32, nearest even, subnormals kept
  function automatic logic [31:0] to_single(input logic [63:0] d);
    logic [31:0] sgn;
    logic [10:0] e;
    logic [63:0] sig, r, rem, half;
    int          fe, sh;
    sgn = {d[63], 31'b0};
    e = d[62:52];
    if (e == 11'h7FF) begin
      if (d[51:0] == 52'd0) return sgn | 32'h7F80_0000;
      return sgn | 32'h7FC0_0000 | {9'b0, d[51:29]};
    end
    if (e == 11'd0) return sgn;
    sig = {11'b0, 1'b1, d[51:0]};
    fe = int'(e) - 896;
    if (fe >= 1) begin
      r = sig >> 29;
      rem = sig & 64'h1FFF_FFFF;
      half = 64'h1000_0000;
      if (rem > half || (rem == half && r[0])) r++;
      if (r == 64'h100_0000) begin
        r = r >> 1;
        fe++;
      end
      if (fe >= 255) return sgn | 32'h7F80_0000;
      return sgn | (32'(fe) << 23) | {9'b0, r[22:0]};
    end
    sh = 30 - fe;
    if (sh > 54) return sgn;
    r = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && r[0])) r++;
    return sgn | r[31:0];
  endfunction

  // exact binary32 to binary64
  function automatic logic [63:0] to_double(input logic [31:0] f);
    int p;
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
    if (f[30:23] != 8'd0) return {f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'b0};
    if (f[22:0] == 23'd0) return {f[31], 63'b0};
    p = 0;
    for (int i = 0; i < 23; i++) if (f[i]) p = i;
    return {f[31], 11'(p + 874), 52'({29'b0, f[22:0]} << (52 - p))};
  endfunction

  // veltkamp split, packed as {hi, lo}
  function automatic logic [63:0] split_parts(input logic [63:0] a);
    real         ar, t, u, h, l;
    logic [31:0] hi, lo;
    ar = $bitstoreal(a);
    t = ar * SplitFactor;
    u = t - ar;
    h = t - u;
    hi = to_single($realtobits(h));
    l = ar - $bitstoreal(to_double(hi));
    lo = to_single($realtobits(l));
    return {hi, lo};
  endfunction

  task automatic send_value(input logic [63:0] v);
    int gap;
    value_bits_i <= v;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    pending_parts.push_back(split_parts(v));
    if (burst_left > 0) burst_left--;
    else begin
      // end of burst: random gap, sometimes a long unbroken run next
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // receiver stall pattern: phases of no stall, light, heavy and long holds
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: stall_i <= 1'b0;
        1: stall_i <= ($urandom_range(0, 9) < 2);
        2: stall_i <= ($urandom_range(0, 9) < 7);
        default: stall_i <= ($urandom_range(0, 15) == 0) ? ~stall_i : stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_parts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: hi %h lo %h", high_part_bits_o, low_part_bits_o);
      end else begin
        want = pending_parts.pop_front();
        if (high_part_bits_o !== want[63:32] || low_part_bits_o !== want[31:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hi %h lo %h, got hi %h lo %h",
                     want[63:32], want[31:0], high_part_bits_o, low_part_bits_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
             64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
             64'h7FF8_0000_0000_0001, 64'hFFF4_5678_9ABC_DEF0,
             64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
             64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
             64'h3FF0_0000_0000_0000, 64'hBFF5_5555_5555_5555,
             64'h47EF_FFFF_E000_0000, 64'h47EF_FFFF_F000_0000,
             64'h47F0_0000_0000_0000, 64'h36A0_0000_0000_0000,
             64'h3690_0000_0000_0000, 64'h3810_0000_0000_0000,
             64'h380F_FFFF_F000_0000, 64'h7FC0_0000_0000_0000,
             64'h4000_0000_1000_0000, 64'h3FF0_0000_3000_0000,
             64'hFFFF_FFFF_FFFF_FFFF, 64'h7E00_0000_0000_0001};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_bits();
    repeat (500) send_value({$urandom, $urandom});
  endtask

  // exponents around the binary32 range, where both parts carry content
  task automatic test_float_range();
    logic [63:0] v;
    repeat (900) begin
      v = {$urandom, $urandom};
      v[62:52] = 11'($urandom_range(1023 - 160, 1023 + 135));
      send_value(v);
    end
  endtask

  // product overflow, subnormals and nan/inf mixed
  task automatic test_edges();
    logic [63:0] v;
    repeat (200) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: v[62:52] = 11'($urandom_range(2015, 2046));
        1: v[62:52] = 11'd0;
        2: v[62:52] = 11'h7FF;
        default: v[51:0] = ($urandom_range(0, 1) ? 52'd0 : 52'hF_FFFF_FFFF_FFFF);
      endcase
      send_value(v);
    end
  endtask

  initial begin
    int waited;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    value_bits_i = '0;
    burst_left = 10;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_bits();
    test_float_range();
    test_edges();
    valid_i <= 1'b0;
    waited = 0;
    while (pending_parts.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (dfps_pkg::Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_parts.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
